// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the top level, the queue and the conversion pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/ecf_pkg.sv =====
// types and constants of the epoch to calendar converter
package ecf_pkg;

	localparam logic signed [53:0] TIME_LIMIT = 54'sd8640000000000000;
	localparam logic [54:0] OFS_MS = 55'd8640000000000000;

	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic oor;
		logic [53:0] ofs_ms;
	} ecf_item_t;

	typedef struct packed {
		logic [19:0] year;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [8:0] day_in_year;
		logic leap_year;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
		logic out_of_range;
	} ecf_result_t;

endpackage

// ===== hw/rtl/epoch_ms_to_calendar_fields.sv =====
// top level of the epoch milliseconds to calendar converter
// Converts a signed time in milliseconds since 1970-01-01T00:00Z into the
// proleptic Gregorian year, month, day, day in year, leap flag and time of day.
// Input side is a queue: drive time_ms and push; a beat is taken on a rising
// edge with push high and full low. Result side is a queue too: the oldest
// result sits on the result ports while empty is low and leaves on an edge
// with pop high. One result comes out for every input beat, in order.
// An input beyond plus or minus 8.64e15 ms gives out_of_range high and all
// other fields zero.
// Throughput is one beat per cycle. A beat runs from the accepting edge to
// empty falling through six three-stage constant dividers (day, 400-year
// era, four-year block, hour, minute, second) and the registers between them.
// When pop stays low the pipeline holds, the queues fill and full rises;
// no beat is lost. Reset empties both queues and the pipeline at once.
`include "assert_macros.svh"
module epoch_ms_to_calendar_fields #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [53:0] time_ms,
	output logic empty,
	input logic pop,
	output logic signed [19:0] year,
	output logic [3:0] month,
	output logic [4:0] day_of_month,
	output logic [8:0] day_in_year,
	output logic leap_year,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second,
	output logic [9:0] millisecond,
	output logic out_of_range
);
	import ecf_pkg::*;

	logic fr_valid;
	ecf_item_t fr_item;
	logic mid_full;
	logic mid_empty;
	logic [$bits(ecf_item_t)-1:0] mid_rdata;
	ecf_item_t mid_item;
	logic bk_ready;
	logic bk_valid;
	ecf_result_t bk_res;
	logic out_full;
	logic [$bits(ecf_result_t)-1:0] out_rdata;
	ecf_result_t res;

	ecf_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .time_ms(time_ms), .full(full),
		.out_valid(fr_valid), .out_item(fr_item), .out_ready(!mid_full)
	);

	ecf_fifo #(.W($bits(ecf_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk(clk), .arst_n(arst_n),
		.push(fr_valid && !mid_full), .wdata(fr_item),
		.pop(!mid_empty && bk_ready),
		.full(mid_full), .empty(mid_empty), .rdata(mid_rdata)
	);

	assign mid_item = mid_rdata;

	ecf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!mid_empty), .in_item(mid_item), .in_ready(bk_ready),
		.out_valid(bk_valid), .out_res(bk_res), .out_ready(!out_full)
	);

	ecf_fifo #(.W($bits(ecf_result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push(bk_valid && !out_full), .wdata(bk_res),
		.pop(pop && !empty),
		.full(out_full), .empty(empty), .rdata(out_rdata)
	);

	assign res = out_rdata;
	assign year = $signed(res.year);
	assign month = res.month;
	assign day_of_month = res.day_of_month;
	assign day_in_year = res.day_in_year;
	assign leap_year = res.leap_year;
	assign hour = res.hour;
	assign minute = res.minute;
	assign second = res.second;
	assign millisecond = res.millisecond;
	assign out_of_range = res.out_of_range;

	`ASSERT_CHK(a_oor_zero, clk, arst_n, (!empty && out_of_range) |-> (res.year == '0 && res.hour == '0 && res.millisecond == '0))

endmodule

// ===== hw/rtl/ecf_fifo.sv =====
// small register queue
`include "assert_macros.svh"
module ecf_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	input logic pop,
	output logic full,
	output logic empty,
	output logic [W-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW:0] FULL_CNT = (AW+1)'(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == FULL_CNT;
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`ASSERT_NEVER(a_overflow, clk, arst_n, push && full && !pop)
	`ASSERT_NEVER(a_underflow, clk, arst_n, pop && empty)

endmodule

// ===== hw/rtl/ecf_cdiv.sv =====
// pipelined divider by a constant: reciprocal multiply, remainder and one correction step
module ecf_cdiv #(
	parameter int N_W = 16,
	parameter int Q_W = 4,
	parameter int DIV = 10,
	parameter int S_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [N_W-1:0] in_num,
	input logic [S_W-1:0] in_side,
	output logic out_valid,
	output logic [Q_W-1:0] out_quo,
	output logic [$clog2(DIV)-1:0] out_rem,
	output logic [S_W-1:0] out_side
);
	localparam int R_W = $clog2(DIV);
	localparam int T_SH = (N_W > 32) ? N_W - 32 : 0;
	localparam int R_SH = N_W + 2;
	localparam int P_W = N_W - T_SH;
	localparam longint unsigned RECIP = (64'd1 << R_SH) / 64'(DIV);
	localparam int M_W = $clog2(RECIP + 64'd1);
	localparam int PR_W = P_W + M_W;
	localparam logic [M_W-1:0] M_C = M_W'(RECIP);
	localparam logic [R_W:0] DIV_C = (R_W+1)'(DIV);

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic [PR_W-1:0] prod_s1;
	logic [R_W:0] nl_s1;
	logic [R_W:0] nl_s2;
	logic [S_W-1:0] side_s1;
	logic [S_W-1:0] side_s2;
	logic [S_W-1:0] side_s3;
	logic [Q_W-1:0] q_s2;
	logic [Q_W-1:0] q_s3;
	logic [R_W:0] qd_s2;
	logic [R_W-1:0] r_s3;
	logic [Q_W-1:0] q_est;
	logic [R_W:0] r_est;
	logic ge;

	// estimate is the true quotient or one below it
	assign q_est = Q_W'(prod_s1 >> (R_SH - T_SH));
	assign r_est = nl_s2 - qd_s2;
	assign ge = r_est >= DIV_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= {{M_W{1'b0}}, in_num[N_W-1:T_SH]} * {{P_W{1'b0}}, M_C};
			nl_s1 <= in_num[R_W:0];
			side_s1 <= in_side;
			q_s2 <= q_est;
			qd_s2 <= (R_W+1)'(q_est) * DIV_C;
			nl_s2 <= nl_s1;
			side_s2 <= side_s1;
			q_s3 <= ge ? q_s2 + 1'b1 : q_s2;
			r_s3 <= ge ? R_W'(r_est - DIV_C) : R_W'(r_est);
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_quo = q_s3;
	assign out_rem = r_s3;
	assign out_side = side_s3;

endmodule

// ===== hw/rtl/ecf_front.sv =====
// input stage: range check and shift of the time to a non-negative offset
module ecf_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic signed [53:0] time_ms,
	output logic full,
	output logic out_valid,
	output ecf_pkg::ecf_item_t out_item,
	input logic out_ready
);
	import ecf_pkg::*;

	logic vld_s1;
	ecf_item_t item_s1;
	logic oor;
	logic [54:0] sum;

	assign oor = (time_ms > TIME_LIMIT) || (time_ms < -TIME_LIMIT);
	assign sum = 55'(time_ms) + OFS_MS;
	assign full = vld_s1 && !out_ready;
	assign out_valid = vld_s1;
	assign out_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1.oor <= oor;
			item_s1.ofs_ms <= oor ? '0 : sum[53:0];
		end
	end

endmodule

// ===== hw/rtl/ecf_back.sv =====
// conversion pipeline: day split, 400-year era split, century and four-year split, month and time of day
`include "assert_macros.svh"
module ecf_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input ecf_pkg::ecf_item_t in_item,
	output logic in_ready,
	output logic out_valid,
	output ecf_pkg::ecf_result_t out_res,
	input logic out_ready
);
	import ecf_pkg::*;

	localparam logic [20:0] YEAR_BASE = 21'(-271999);
	localparam logic [27:0] ERA_OFS = 28'd65122;
	localparam logic [17:0] CENT_1 = 18'd36524;
	localparam logic [17:0] CENT_2 = 18'd73048;
	localparam logic [17:0] CENT_3 = 18'd109572;
	localparam logic [10:0] YR_1 = 11'd365;
	localparam logic [10:0] YR_2 = 11'd730;
	localparam logic [10:0] YR_3 = 11'd1095;

	typedef struct packed {
		logic oor;
		logic [9:0] low;
	} side_a_t;

	typedef struct packed {
		logic oor;
		logic [26:0] msday;
	} side_b_t;

	typedef struct packed {
		logic oor;
		logic [26:0] msday;
		logic [10:0] era;
		logic [1:0] cent;
	} side_d_t;

	typedef struct packed {
		logic oor;
		logic [19:0] year;
		logic [3:0] month;
		logic [4:0] dom;
		logic [8:0] diy;
		logic leap;
	} date_t;

	typedef struct packed {
		date_t date;
		logic [4:0] hour;
	} side_m_t;

	typedef struct packed {
		date_t date;
		logic [4:0] hour;
		logic [5:0] minute;
	} side_s_t;

	logic adv;

	// days since the shifted epoch
	side_a_t sa_in, sa;
	logic va;
	logic [27:0] qa;
	logic [16:0] ra;

	assign sa_in = '{oor: in_item.oor, low: in_item.ofs_ms[9:0]};

	ecf_cdiv #(.N_W(44), .Q_W(28), .DIV(84375), .S_W($bits(side_a_t))) u_div_day (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid),
		.in_num(in_item.ofs_ms[53:10]), .in_side(sa_in),
		.out_valid(va), .out_quo(qa), .out_rem(ra), .out_side(sa)
	);

	logic vld_s2;
	logic [27:0] z_s2;
	logic [26:0] msday_s2;
	logic oor_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s2 <= qa + ERA_OFS;
			msday_s2 <= {ra, sa.low};
			oor_s2 <= sa.oor;
		end
	end

	// 400-year eras
	side_b_t sb_in, sb;
	logic vb;
	logic [10:0] qb;
	logic [17:0] rb;

	assign sb_in = '{oor: oor_s2, msday: msday_s2};

	ecf_cdiv #(.N_W(28), .Q_W(11), .DIV(146097), .S_W($bits(side_b_t))) u_div_era (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vld_s2),
		.in_num(z_s2), .in_side(sb_in),
		.out_valid(vb), .out_quo(qb), .out_rem(rb), .out_side(sb)
	);

	logic [1:0] cent;
	logic [17:0] cent_ofs;

	always_comb begin
		cent = 2'({1'b0, rb >= CENT_1} + {1'b0, rb >= CENT_2} + {1'b0, rb >= CENT_3});
		unique case (cent)
			2'd0: cent_ofs = '0;
			2'd1: cent_ofs = CENT_1;
			2'd2: cent_ofs = CENT_2;
			default: cent_ofs = CENT_3;
		endcase
	end

	logic vld_s3;
	logic [15:0] rc_s3;
	side_d_t sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s3 <= 16'(rb - cent_ofs);
			sd_s3 <= '{oor: sb.oor, msday: sb.msday, era: qb, cent: cent};
		end
	end

	// four-year blocks inside a century
	side_d_t sd;
	logic vd;
	logic [4:0] qd;
	logic [10:0] rd;

	ecf_cdiv #(.N_W(16), .Q_W(5), .DIV(1461), .S_W($bits(side_d_t))) u_div_quad (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vld_s3),
		.in_num(rc_s3), .in_side(sd_s3),
		.out_valid(vd), .out_quo(qd), .out_rem(rd), .out_side(sd)
	);

	logic [1:0] yy;
	logic [10:0] yy_ofs;
	logic [20:0] c100;
	logic [20:0] yr_sum;

	always_comb begin
		yy = 2'({1'b0, rd >= YR_1} + {1'b0, rd >= YR_2} + {1'b0, rd >= YR_3});
		unique case (yy)
			2'd0: yy_ofs = '0;
			2'd1: yy_ofs = YR_1;
			2'd2: yy_ofs = YR_2;
			default: yy_ofs = YR_3;
		endcase
		unique case (sd.cent)
			2'd0: c100 = 21'd0;
			2'd1: c100 = 21'd100;
			2'd2: c100 = 21'd200;
			default: c100 = 21'd300;
		endcase
		yr_sum = {2'b0, sd.era, 8'b0} + {3'b0, sd.era, 7'b0} + {6'b0, sd.era, 4'b0}
			+ c100 + {14'b0, qd, 2'b0} + {19'b0, yy};
	end

	logic vld_s4;
	logic [19:0] year_s4;
	logic [8:0] diy_s4;
	logic leap_s4;
	logic [26:0] msday_s4;
	logic oor_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			year_s4 <= 20'(YEAR_BASE + yr_sum);
			diy_s4 <= 9'(rd - yy_ofs);
			leap_s4 <= (yy == 2'd3) && !((qd == 5'd24) && (sd.cent != 2'd3));
			msday_s4 <= sd.msday;
			oor_s4 <= sd.oor;
		end
	end

	// month from cumulative day bounds
	logic [3:0] mon;
	logic [8:0] mon_start;

	always_comb begin
		mon = '0;
		for (int k = 1; k < 12; k++) begin
			if (diy_s4 >= MONTH_START[k] + ((k >= 2) ? {8'b0, leap_s4} : 9'd0)) begin
				mon = 4'(k);
			end
		end
		mon_start = MONTH_START[mon] + ((mon >= 4'd2) ? {8'b0, leap_s4} : 9'd0);
	end

	logic vld_s5;
	date_t date_s5;
	logic [26:0] msday_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			date_s5 <= '{oor: oor_s4, year: year_s4, month: mon,
				dom: 5'(diy_s4 - mon_start + 9'd1), diy: diy_s4, leap: leap_s4};
			msday_s5 <= msday_s4;
		end
	end

	// time of day
	date_t sh;
	logic vh;
	logic [4:0] qh;
	logic [21:0] rh;

	ecf_cdiv #(.N_W(27), .Q_W(5), .DIV(3600000), .S_W($bits(date_t))) u_div_hour (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vld_s5),
		.in_num(msday_s5), .in_side(date_s5),
		.out_valid(vh), .out_quo(qh), .out_rem(rh), .out_side(sh)
	);

	side_m_t sm_in, sm;
	logic vm;
	logic [5:0] qm;
	logic [15:0] rm;

	assign sm_in = '{date: sh, hour: qh};

	ecf_cdiv #(.N_W(22), .Q_W(6), .DIV(60000), .S_W($bits(side_m_t))) u_div_min (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vh),
		.in_num(rh), .in_side(sm_in),
		.out_valid(vm), .out_quo(qm), .out_rem(rm), .out_side(sm)
	);

	side_s_t ss_in, ss;
	logic vs;
	logic [5:0] qs;
	logic [9:0] rs;

	assign ss_in = '{date: sm.date, hour: sm.hour, minute: qm};

	ecf_cdiv #(.N_W(16), .Q_W(6), .DIV(1000), .S_W($bits(side_s_t))) u_div_sec (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vm),
		.in_num(rm), .in_side(ss_in),
		.out_valid(vs), .out_quo(qs), .out_rem(rs), .out_side(ss)
	);

	assign adv = !vs || out_ready;
	assign in_ready = adv;
	assign out_valid = vs;

	always_comb begin
		if (ss.date.oor) begin
			out_res = '0;
			out_res.out_of_range = 1'b1;
		end else begin
			out_res.year = ss.date.year;
			out_res.month = ss.date.month;
			out_res.day_of_month = ss.date.dom;
			out_res.day_in_year = ss.date.diy;
			out_res.leap_year = ss.date.leap;
			out_res.hour = ss.hour;
			out_res.minute = ss.minute;
			out_res.second = qs;
			out_res.millisecond = rs;
			out_res.out_of_range = 1'b0;
		end
	end

	`ASSERT_CHK(a_month_range, clk, arst_n, out_valid |-> (out_res.month <= 4'd11))
	`ASSERT_CHK(a_dom_nonzero, clk, arst_n, (out_valid && !out_res.out_of_range) |-> (out_res.day_of_month != 5'd0))

endmodule
